[design/mpe_pkg.sv]
// package: function codes, tag bytes and the encoded-item type for the msgpack item encoder
`timescale 1ns / 1ps
`default_nettype none
package mpe_pkg;

    // value kinds carried on the func field
    localparam logic [3:0] FN_NIL     = 4'd0;
    localparam logic [3:0] FN_BOOL    = 4'd1;
    localparam logic [3:0] FN_INT32   = 4'd2;
    localparam logic [3:0] FN_UINT32  = 4'd3;
    localparam logic [3:0] FN_INT64   = 4'd4;
    localparam logic [3:0] FN_UINT64  = 4'd5;
    localparam logic [3:0] FN_F32     = 4'd6;
    localparam logic [3:0] FN_F64     = 4'd7;
    localparam logic [3:0] FN_ARR     = 4'd8;
    localparam logic [3:0] FN_MAP     = 4'd9;
    localparam logic [3:0] FN_STR     = 4'd10;
    localparam logic [3:0] FN_BIN     = 4'd11;
    localparam logic [3:0] FN_UUID    = 4'd12;
    localparam logic [3:0] FN_PAYLOAD = 4'd13;

    // configuration register indexes
    localparam logic [7:0] CFG_COMPAT_MODE   = 8'd0;
    localparam logic [7:0] CFG_UUID_EXT_TYPE = 8'd1;
    localparam logic [7:0] UUID_EXT_RESET    = 8'd30;

    // msgpack tag bytes
    localparam logic [7:0] TAG_NIL    = 8'hc0;
    localparam logic [7:0] TAG_FALSE  = 8'hc2;
    localparam logic [7:0] TAG_TRUE   = 8'hc3;
    localparam logic [7:0] TAG_BIN8   = 8'hc4;
    localparam logic [7:0] TAG_BIN16  = 8'hc5;
    localparam logic [7:0] TAG_BIN32  = 8'hc6;
    localparam logic [7:0] TAG_F32    = 8'hca;
    localparam logic [7:0] TAG_F64    = 8'hcb;
    localparam logic [7:0] TAG_UINT8  = 8'hcc;
    localparam logic [7:0] TAG_UINT16 = 8'hcd;
    localparam logic [7:0] TAG_UINT32 = 8'hce;
    localparam logic [7:0] TAG_UINT64 = 8'hcf;
    localparam logic [7:0] TAG_INT8   = 8'hd0;
    localparam logic [7:0] TAG_INT16  = 8'hd1;
    localparam logic [7:0] TAG_INT32  = 8'hd2;
    localparam logic [7:0] TAG_INT64  = 8'hd3;
    localparam logic [7:0] TAG_EXT16B = 8'hd8;
    localparam logic [7:0] TAG_STR8   = 8'hd9;
    localparam logic [7:0] TAG_STR16  = 8'hda;
    localparam logic [7:0] TAG_STR32  = 8'hdb;
    localparam logic [7:0] TAG_ARR16  = 8'hdc;
    localparam logic [7:0] TAG_ARR32  = 8'hdd;
    localparam logic [7:0] TAG_MAP16  = 8'hde;
    localparam logic [7:0] TAG_MAP32  = 8'hdf;
    localparam logic [7:0] FIX_ARR    = 8'h90;
    localparam logic [7:0] FIX_MAP    = 8'h80;
    localparam logic [7:0] FIX_STR    = 8'ha0;

    // number of bytes following the first byte
    localparam logic [3:0] DLEN_0 = 4'd0;
    localparam logic [3:0] DLEN_1 = 4'd1;
    localparam logic [3:0] DLEN_2 = 4'd2;
    localparam logic [3:0] DLEN_4 = 4'd4;
    localparam logic [3:0] DLEN_8 = 4'd8;

    // one classified item: first byte, count of following bytes, operand
    typedef struct packed {
        logic [7:0]  first;
        logic [3:0]  dlen;
        logic [63:0] data;
    } t_enc;

endpackage
`default_nettype wire

[design/msgpack_item_encoder_top.sv]
// msgpack item encoder: input register, classify stage, byte serialiser, output register
//
// Use: each input word (i_func, i_value) names one value kind and its operand; the
// block emits the MessagePack bytes for it, most significant first, one byte per
// output word, with o_last high on the final byte of that input word. Container,
// string, binary and UUID kinds give only their headers; payload bytes follow as
// payload words. Kinds 14 and 15 produce nothing.
// Channels: input (i_valid/o_ready), output (o_valid/i_ready), and a config write
// channel (i_cfg_valid/o_cfg_ready, always ready) with register 0 compat_mode and
// register 1 uuid_ext_type; write config only while the block is empty.
// Path: the first byte of a word reaches the output after passing through the input
// register, classify register, serialiser and output register, in that order.
// Throughput: one output byte per cycle while the receiver keeps i_ready high; a word
// of n bytes (1 to 9) occupies the serialiser until all n bytes have left, so single-byte
// words stream at one word per cycle and multi-byte headers hold the input back while their bytes drain.
// Reset: pipeline emptied, compat_mode cleared, uuid_ext_type set to 30.
// Stall: when the receiver drops i_ready the output word holds and backpressure
// ripples back stage by stage to o_ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_item_encoder_top
    import mpe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_func,
    input  wire logic [63:0] i_value,
    // output bytes
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // configuration registers
    logic       r_compat_mode;
    logic [7:0] r_uuid_ext_type;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compat_mode   <= 1'b0;
            r_uuid_ext_type <= UUID_EXT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COMPAT_MODE) begin
                r_compat_mode <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_UUID_EXT_TYPE) begin
                r_uuid_ext_type <= i_cfg_data;
            end
        end
    end

    // pipeline registers
    logic        r_in_valid;
    logic [3:0]  r_in_func;
    logic [63:0] r_in_value;
    logic        r_enc_valid;
    t_enc        r_enc;
    logic [71:0] r_ser_buf;
    logic [3:0]  r_ser_cnt;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        n_enc_valid;
    t_enc        n_enc;
    logic [71:0] n_ser_buf;
    logic [3:0]  n_ser_cnt;
    logic        out_load;
    logic        ser_take;
    logic        enc_adv;

    // unsigned 32-bit in the smallest form
    function automatic t_enc enc_u32(input logic [31:0] u);
        t_enc e;
        e.data = {32'd0, u};
        if (u <= 32'd127) begin
            e.first = u[7:0];
            e.dlen  = DLEN_0;
        end else if (u <= 32'hff) begin
            e.first = TAG_UINT8;
            e.dlen  = DLEN_1;
        end else if (u <= 32'hffff) begin
            e.first = TAG_UINT16;
            e.dlen  = DLEN_2;
        end else begin
            e.first = TAG_UINT32;
            e.dlen  = DLEN_4;
        end
        return e;
    endfunction

    // signed 32-bit in the smallest form
    function automatic t_enc enc_s32(input logic [31:0] b);
        t_enc e;
        e.data = {32'd0, b};
        if (!b[31]) begin
            e = enc_u32(b);
        end else if (b >= 32'hffffffe0) begin
            e.first = b[7:0];
            e.dlen  = DLEN_0;
        end else if (b >= 32'hffffff80) begin
            e.first = TAG_INT8;
            e.dlen  = DLEN_1;
        end else if (b >= 32'hffff8000) begin
            e.first = TAG_INT16;
            e.dlen  = DLEN_2;
        end else begin
            e.first = TAG_INT32;
            e.dlen  = DLEN_4;
        end
        return e;
    endfunction

    // length headers of arrays and maps
    function automatic t_enc enc_len(input logic [31:0] len, input logic [7:0] fix,
                                     input logic [7:0] t16, input logic [7:0] t32);
        t_enc e;
        e.data = {32'd0, len};
        if (len <= 32'd15) begin
            e.first = fix | len[7:0];
            e.dlen  = DLEN_0;
        end else if (len <= 32'hffff) begin
            e.first = t16;
            e.dlen  = DLEN_2;
        end else begin
            e.first = t32;
            e.dlen  = DLEN_4;
        end
        return e;
    endfunction

    // string headers, str8 left out in compat mode
    function automatic t_enc enc_str(input logic [31:0] len, input logic compat);
        t_enc e;
        e.data = {32'd0, len};
        if (len <= 32'd31) begin
            e.first = FIX_STR | len[7:0];
            e.dlen  = DLEN_0;
        end else if (len <= 32'hff && !compat) begin
            e.first = TAG_STR8;
            e.dlen  = DLEN_1;
        end else if (len <= 32'hffff) begin
            e.first = TAG_STR16;
            e.dlen  = DLEN_2;
        end else begin
            e.first = TAG_STR32;
            e.dlen  = DLEN_4;
        end
        return e;
    endfunction

    // stage 1: input register
    assign o_ready = !r_in_valid || enc_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_func  <= i_func;
            r_in_value <= i_value;
        end
    end

    // stage 2: classify the kind into first byte and following byte count
    always_comb begin
        n_enc       = '{first: TAG_NIL, dlen: DLEN_0, data: r_in_value};
        n_enc_valid = r_in_valid;
        unique case (r_in_func)
            FN_NIL:     n_enc.first = TAG_NIL;
            FN_BOOL:    n_enc.first = (r_in_value != 64'd0) ? TAG_TRUE : TAG_FALSE;
            FN_INT32:   n_enc = enc_s32(r_in_value[31:0]);
            FN_UINT32:  n_enc = enc_u32(r_in_value[31:0]);
            FN_INT64: begin
                if (r_in_value[63:32] == 32'd0) begin
                    n_enc = enc_u32(r_in_value[31:0]);
                end else if (r_in_value >= 64'hffffffff80000000) begin
                    n_enc = enc_s32(r_in_value[31:0]);
                end else begin
                    n_enc.first = TAG_INT64;
                    n_enc.dlen  = DLEN_8;
                end
            end
            FN_UINT64: begin
                if (r_in_value[63:32] == 32'd0) begin
                    n_enc = enc_u32(r_in_value[31:0]);
                end else begin
                    n_enc.first = TAG_UINT64;
                    n_enc.dlen  = DLEN_8;
                end
            end
            FN_F32: begin
                n_enc.first = TAG_F32;
                n_enc.dlen  = DLEN_4;
            end
            FN_F64: begin
                n_enc.first = TAG_F64;
                n_enc.dlen  = DLEN_8;
            end
            FN_ARR:     n_enc = enc_len(r_in_value[31:0], FIX_ARR, TAG_ARR16, TAG_ARR32);
            FN_MAP:     n_enc = enc_len(r_in_value[31:0], FIX_MAP, TAG_MAP16, TAG_MAP32);
            FN_STR:     n_enc = enc_str(r_in_value[31:0], r_compat_mode);
            FN_BIN: begin
                if (r_compat_mode) begin
                    n_enc = enc_str(r_in_value[31:0], 1'b1);
                end else if (r_in_value[31:0] <= 32'hff) begin
                    n_enc.first = TAG_BIN8;
                    n_enc.dlen  = DLEN_1;
                end else if (r_in_value[31:0] <= 32'hffff) begin
                    n_enc.first = TAG_BIN16;
                    n_enc.dlen  = DLEN_2;
                end else begin
                    n_enc.first = TAG_BIN32;
                    n_enc.dlen  = DLEN_4;
                end
            end
            FN_UUID: begin
                n_enc.first = TAG_EXT16B;
                n_enc.dlen  = DLEN_1;
                n_enc.data  = {56'd0, r_uuid_ext_type};
            end
            FN_PAYLOAD: n_enc.first = r_in_value[7:0];
            // unused kinds give no bytes and are dropped here
            default:    n_enc_valid = 1'b0;
        endcase
    end

    assign enc_adv = !r_enc_valid || ser_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_valid <= 1'b0;
        end else if (enc_adv) begin
            r_enc_valid <= n_enc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc_adv && n_enc_valid) begin
            r_enc <= n_enc;
        end
    end

    // stage 3: serialiser, bytes left-aligned in a shift buffer
    assign out_load = (r_ser_cnt != 4'd0) && (!r_out_valid || i_ready);
    assign ser_take = r_enc_valid && ((r_ser_cnt == 4'd0) || ((r_ser_cnt == 4'd1) && out_load));

    always_comb begin
        n_ser_buf = r_ser_buf;
        n_ser_cnt = r_ser_cnt;
        if (out_load) begin
            n_ser_buf = {r_ser_buf[63:0], 8'd0};
            n_ser_cnt = r_ser_cnt - 4'd1;
        end
        if (ser_take) begin
            n_ser_cnt = r_enc.dlen + 4'd1;
            case (r_enc.dlen)
                DLEN_1:  n_ser_buf = {r_enc.first, r_enc.data[7:0], 56'd0};
                DLEN_2:  n_ser_buf = {r_enc.first, r_enc.data[15:0], 48'd0};
                DLEN_4:  n_ser_buf = {r_enc.first, r_enc.data[31:0], 32'd0};
                DLEN_8:  n_ser_buf = {r_enc.first, r_enc.data};
                default: n_ser_buf = {r_enc.first, 64'd0};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_cnt <= 4'd0;
        end else begin
            r_ser_cnt <= n_ser_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ser_buf <= n_ser_buf;
    end

    // stage 4: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_ser_buf[71:64];
            r_out_last <= (r_ser_cnt == 4'd1);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    // checks
    a_ser_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_cnt <= 4'd9)
        else $error("serialiser count out of range");

    a_no_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !out_load)
        else $error("output word overwritten while stalled");

    a_cnt_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ser_take |=> r_ser_cnt <= $past(r_ser_cnt))
        else $error("serialiser count rose without a new word");

    a_dlen_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc_valid |-> (r_enc.dlen == DLEN_0 || r_enc.dlen == DLEN_1 ||
                         r_enc.dlen == DLEN_2 || r_enc.dlen == DLEN_4 ||
                         r_enc.dlen == DLEN_8))
        else $error("illegal byte count from classify stage");

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_ser_cnt == 4'd1) |=> (r_out_valid && r_out_last))
        else $error("final byte not marked last");

endmodule
`default_nettype wire

[verif/tb_msgpack_item_encoder_top.sv]
// testbench: msgpack item encoder byte stream checked against a local encoding predictor
`timescale 1ns / 1ps
module tb_msgpack_item_encoder_top
    import mpe_pkg::*;
();

    // kinds outside the defined set, expected to produce no bytes
    localparam logic [3:0] FN_SPARE_A = 4'd14;
    localparam logic [3:0] FN_SPARE_B = 4'd15;
    // register index past the end of the register list
    localparam logic [7:0] CFG_UNUSED = 8'd2;

    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_func;
    logic [63:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    // expected byte stream and local copy of the registers
    t_enc_byte   expected_bytes[$];
    t_enc_byte   want_byte;
    logic        compat_q;
    logic [7:0]  uuid_type_q;

    int          errors      = 0;
    int          cycle_count = 0;
    int          items_sent  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;

    msgpack_item_encoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: long hold-off when requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each output word with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, o_out_byte, o_last);
                errors++;
            end else begin
                want_byte = expected_bytes.pop_front();
                if (o_out_byte !== want_byte.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want_byte.data, o_out_byte);
                    errors++;
                end
                if (o_last !== want_byte.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want_byte.last, o_last);
                    errors++;
                end
            end
        end
    end

    // smallest unsigned integer form
    function automatic void size_unsigned(input logic [31:0] u, output logic [7:0] tag,
                                          output int follow, output logic [63:0] operand);
        operand = {32'd0, u};
        if (u <= 32'd127) begin
            tag = u[7:0]; follow = 0;
        end else if (u <= 32'hff) begin
            tag = TAG_UINT8; follow = 1;
        end else if (u <= 32'hffff) begin
            tag = TAG_UINT16; follow = 2;
        end else begin
            tag = TAG_UINT32; follow = 4;
        end
    endfunction

    // smallest signed form for a 32-bit two's complement value
    function automatic void size_signed(input logic [31:0] bits, output logic [7:0] tag,
                                        output int follow, output logic [63:0] operand);
        operand = {32'd0, bits};
        if (!bits[31]) begin
            size_unsigned(bits, tag, follow, operand);
        end else if ($signed(bits) >= -32) begin
            tag = bits[7:0]; follow = 0;
        end else if ($signed(bits) >= -128) begin
            tag = TAG_INT8; follow = 1;
        end else if ($signed(bits) >= -32768) begin
            tag = TAG_INT16; follow = 2;
        end else begin
            tag = TAG_INT32; follow = 4;
        end
    endfunction

    // array and map length headers
    function automatic void size_length(input logic [31:0] len, input logic [7:0] fix,
                                        input logic [7:0] t16, input logic [7:0] t32,
                                        output logic [7:0] tag, output int follow,
                                        output logic [63:0] operand);
        operand = {32'd0, len};
        if (len <= 32'd15) begin
            tag = fix | len[7:0]; follow = 0;
        end else if (len <= 32'hffff) begin
            tag = t16; follow = 2;
        end else begin
            tag = t32; follow = 4;
        end
    endfunction

    // string length header, str8 skipped in compat mode
    function automatic void size_string(input logic [31:0] len, output logic [7:0] tag,
                                        output int follow, output logic [63:0] operand);
        operand = {32'd0, len};
        if (len <= 32'd31) begin
            tag = FIX_STR | len[7:0]; follow = 0;
        end else if (len <= 32'hff && !compat_q) begin
            tag = TAG_STR8; follow = 1;
        end else if (len <= 32'hffff) begin
            tag = TAG_STR16; follow = 2;
        end else begin
            tag = TAG_STR32; follow = 4;
        end
    endfunction

    // work out the bytes for one accepted word and queue them
    function automatic void encode_item_bytes(input logic [3:0] fn, input logic [63:0] val);
        logic [7:0]  tag;
        int          follow;
        logic [63:0] operand;
        logic [31:0] lo;
        lo      = val[31:0];
        tag     = 8'h00;
        follow  = 0;
        operand = 64'd0;
        case (fn)
            FN_NIL:     tag = TAG_NIL;
            FN_BOOL:    tag = (val != 64'd0) ? TAG_TRUE : TAG_FALSE;
            FN_INT32:   size_signed(lo, tag, follow, operand);
            FN_UINT32:  size_unsigned(lo, tag, follow, operand);
            FN_INT64: begin
                if (val <= 64'hffff_ffff)
                    size_unsigned(lo, tag, follow, operand);
                else if (val >= 64'hffff_ffff_8000_0000)
                    size_signed(lo, tag, follow, operand);
                else begin
                    tag = TAG_INT64; follow = 8; operand = val;
                end
            end
            FN_UINT64: begin
                if (val <= 64'hffff_ffff)
                    size_unsigned(lo, tag, follow, operand);
                else begin
                    tag = TAG_UINT64; follow = 8; operand = val;
                end
            end
            FN_F32: begin
                tag = TAG_F32; follow = 4; operand = {32'd0, lo};
            end
            FN_F64: begin
                tag = TAG_F64; follow = 8; operand = val;
            end
            FN_ARR:     size_length(lo, FIX_ARR, TAG_ARR16, TAG_ARR32, tag, follow, operand);
            FN_MAP:     size_length(lo, FIX_MAP, TAG_MAP16, TAG_MAP32, tag, follow, operand);
            FN_STR:     size_string(lo, tag, follow, operand);
            FN_BIN: begin
                operand = {32'd0, lo};
                if (compat_q)
                    size_string(lo, tag, follow, operand);
                else if (lo <= 32'hff) begin
                    tag = TAG_BIN8; follow = 1;
                end else if (lo <= 32'hffff) begin
                    tag = TAG_BIN16; follow = 2;
                end else begin
                    tag = TAG_BIN32; follow = 4;
                end
            end
            FN_UUID: begin
                tag = TAG_EXT16B; follow = 1; operand = {56'd0, uuid_type_q};
            end
            FN_PAYLOAD: tag = val[7:0];
            default:    return;
        endcase
        expected_bytes.push_back('{tag, follow == 0});
        for (int b = follow - 1; b >= 0; b--)
            expected_bytes.push_back('{operand[8*b +: 8], b == 0});
    endfunction

    // offer one word, hold it until accepted; starts and ends at a falling edge
    task automatic send_item(input logic [3:0] fn, input logic [63:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_item_bytes(fn, val);
        if (fn <= FN_PAYLOAD) items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and let everything expected come out
    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write, only issued while the block is empty
    task automatic write_register(input logic [7:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_COMPAT_MODE)
            compat_q = data[0];
        else if (idx == CFG_UUID_EXT_TYPE)
            uuid_type_q = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        // wait for another falling edge with i_cfg_valid low so a following write starts on a later edge
        @(negedge i_clk);
    endtask

    // operand spread over every encoding size, both signs
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(63, 0);
        if ($urandom_range(3) == 0) v = ~v;
        return v;
    endfunction

    // one random word or a short well-formed run of header plus payload words
    task automatic send_random_item();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 12) begin
            len = $urandom_range(8);
            send_item($urandom_range(1) ? FN_STR : FN_BIN, {$urandom, 32'(len)});
            repeat (len) send_item(FN_PAYLOAD, random_operand());
        end else if (pick < 16) begin
            send_item(FN_UUID, random_operand());
            repeat (16) send_item(FN_PAYLOAD, random_operand());
        end else if (pick < 19) begin
            send_item($urandom_range(1) ? FN_SPARE_A : FN_SPARE_B, random_operand());
        end else begin
            send_item(4'($urandom_range(13)), random_operand());
        end
    endtask

    task automatic run_random(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) send_random_item();
    endtask

    // nil, bool, floats, payload and the unused kinds
    task automatic test_scalar_kinds();
        send_item(FN_NIL,     64'hffff_ffff_ffff_ffff);
        send_item(FN_BOOL,    64'd0);
        send_item(FN_BOOL,    64'h8000_0000_0000_0000);
        send_item(FN_F32,     64'hdead_beef_3f80_0000);
        send_item(FN_F64,     64'hffff_ffff_ffff_ffff);
        send_item(FN_PAYLOAD, 64'h1234_5678_9abc_def5);
        send_item(FN_SPARE_A, 64'h0123_4567_89ab_cdef);
        send_item(FN_SPARE_B, 64'd0);
        wait_until_idle();
    endtask

    // integer size boundaries
    task automatic test_integer_widths();
        send_item(FN_INT32,  64'h0000_0000_ffff_ffe0);
        send_item(FN_INT32,  64'hffff_ffff_ffff_ffdf);
        send_item(FN_INT32,  64'h0000_0000_ffff_7fff);
        send_item(FN_INT32,  64'h0000_0000_7fff_ffff);
        send_item(FN_UINT32, 64'hffff_ffff_0000_00c8);
        send_item(FN_UINT32, 64'h0000_0000_0000_ffff);
        send_item(FN_INT64,  64'hffff_ffff_7fff_ffff);
        send_item(FN_INT64,  64'hffff_ffff_8000_0000);
        send_item(FN_INT64,  64'h8000_0000_0000_0000);
        send_item(FN_UINT64, 64'hffff_ffff_ffff_ffff);
        wait_until_idle();
    endtask

    // container, string, binary and uuid headers
    task automatic test_length_headers();
        send_item(FN_ARR,  64'h0000_0000_0000_000f);
        send_item(FN_ARR,  64'h0000_0000_0001_0000);
        send_item(FN_MAP,  64'hffff_ffff_0000_0010);
        send_item(FN_STR,  64'h0000_0000_0000_0020);
        send_item(FN_STR,  64'h0000_0000_0000_ffff);
        send_item(FN_BIN,  64'h0000_0000_0000_0100);
        send_item(FN_UUID, 64'd0);
        wait_until_idle();
    endtask

    // compat mode, uuid type extremes and writes to an unused index
    task automatic test_compat_and_uuid_type();
        write_register(CFG_COMPAT_MODE, 8'h01);
        write_register(CFG_UUID_EXT_TYPE, 8'hff);
        send_item(FN_BIN,  64'h0000_0000_0000_001f);
        send_item(FN_STR,  64'h0000_0000_0000_00ff);
        send_item(FN_BIN,  64'h0000_0000_0000_0100);
        send_item(FN_BIN,  64'h0000_0000_0001_1170);
        send_item(FN_UUID, 64'h0000_0000_0000_0000);
        run_random(40);
        wait_until_idle();
        write_register(CFG_UNUSED, 8'hff);
        write_register(8'hff, 8'h00);
        run_random(20);
        wait_until_idle();
        write_register(CFG_COMPAT_MODE, 8'h00);
        write_register(CFG_UUID_EXT_TYPE, 8'h00);
        run_random(40);
        wait_until_idle();
        write_register(CFG_UUID_EXT_TYPE, UUID_EXT_RESET);
    endtask

    // random traffic under each idling pattern
    task automatic test_idle_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_random(90);
        send_idle_pct = 61; recv_stall_pct = 0;
        run_random(90);
        send_idle_pct = 0;  recv_stall_pct = 61;
        run_random(90);
        wait_until_idle();
        write_register(CFG_COMPAT_MODE, 8'h01);
        send_idle_pct = 27; recv_stall_pct = 27;
        run_random(90);
        wait_until_idle();
        write_register(CFG_COMPAT_MODE, 8'h00);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_output_hold_off();
        @(posedge i_clk);
        hold_left = 300;
        @(negedge i_clk);
        run_random(40);
        wait_until_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FN_NIL;
        i_value     = 64'd0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COMPAT_MODE;
        i_cfg_data  = 8'd0;
        compat_q    = 1'b0;
        uuid_type_q = UUID_EXT_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_scalar_kinds();
        test_integer_widths();
        test_length_headers();
        test_compat_and_uuid_type();
        test_idle_phases();
        test_output_hold_off();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
